// File: src/lcwe_pkg.sv
// ----------------------------------------------------------------------------
// lcwe_pkg
// Shared types and constants for the lru cache with expiry.
// ----------------------------------------------------------------------------
`default_nettype none

package lcwe_pkg;

   localparam int DEPTH   = 16;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int RANK_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int WORD_W  = 32;

   localparam logic [1:0] CMD_GET  = 2'd0;
   localparam logic [1:0] CMD_PUSH = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;

   localparam logic CSR_CAPACITY = 1'b0;
   localparam logic CSR_MAX_AGE  = 1'b1;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] data;
      logic               evicted;
   } rsp_type;

   typedef struct packed {
      logic [WORD_W-1:0] key;
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] stamp;
   } entry_type;

   // capacity of zero acts as one, anything above the depth acts as the depth
   function automatic logic [CNT_W-1:0] eff_capacity(input logic [4:0] cap);
      int c;
      c = int'(cap);
      if (c < 1) c = 1;
      if (c > DEPTH) c = DEPTH;
      return CNT_W'(c);
   endfunction

endpackage

`default_nettype wire

// File: src/lru_cache_with_expiry_top.sv
// ----------------------------------------------------------------------------
// lru_cache_with_expiry_top
// Key-value store in least-recently-used order with a read age limit.
// ----------------------------------------------------------------------------
// Entries live in a synchronous memory (key, value, stamp) beside a rank
// memory; valid bits sit in flip-flops. A get or push is taken in the idle
// state, then walks all DEPTH entries once to find the key and the least recent
// entry, decides in ST_DECIDE, then walks the rank memory again to renumber
// the recency order, and loads the result in ST_DONE. A get that misses or
// finds a stale entry skips the renumbering walk. A tick or an unused command
// goes from the idle state straight to ST_DONE, without either walk. One
// transfer is worked on at a time; the next may be taken while the previous
// result still waits on rsp_stall, and a waiting result holds the block in its
// last cycle. There is no clearing pass.
`default_nettype none

module lru_cache_with_expiry_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire lcwe_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lcwe_pkg::rsp_type     rsp_payload,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [31:0]      csr_wdata
);
   import lcwe_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_RANK   = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   entry_type           kvs_mem [DEPTH];
   logic [RANK_W-1:0]   rank_mem [DEPTH];

   logic [2:0]          state_ff, state_in;
   logic [4:0]          cap_ff;
   logic [WORD_W-1:0]   max_age_ff;
   logic [WORD_W-1:0]   time_ff;
   logic [CNT_W-1:0]    occ_ff;
   logic [DEPTH-1:0]    valid_ff;
   req_type             cur_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                rd_v_ff;
   logic [ADDR_W-1:0]   rd_addr_ff;
   entry_type           kvs_q_ff;
   logic [RANK_W-1:0]   rank_q_ff;
   logic                found_ff;
   logic [ADDR_W-1:0]   slot_ff;
   logic [RANK_W-1:0]   slot_rank_ff;
   entry_type           slot_ent_ff;
   logic                vic_found_ff;
   logic [ADDR_W-1:0]   vic_ff;
   logic [RANK_W:0]     thr_ff;
   logic [ADDR_W-1:0]   tgt_ff;
   logic                hit_ff;
   logic [WORD_W-1:0]   data_ff;
   logic                ev_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic                issue;
   logic [ADDR_W-1:0]   rd_addr;
   logic                kvs_we;
   logic [ADDR_W-1:0]   kvs_waddr;
   entry_type           kvs_wdata;
   logic                rank_we;
   logic [RANK_W-1:0]   rank_wdata;
   logic                out_free;
   logic                evict;
   logic [DEPTH-1:0]    valid_post;
   logic                free_found;
   logic [ADDR_W-1:0]   free_slot;
   logic [WORD_W-1:0]   age;
   logic [CNT_W-1:0]    occ_last;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign issue   = (state_ff == ST_SCAN || state_ff == ST_RANK) && (cnt_ff < CNT_W'(DEPTH));
   assign rd_addr = cnt_ff[ADDR_W-1:0];
   assign occ_last = occ_ff - CNT_W'(1);
   assign age     = time_ff - slot_ent_ff.stamp;
   assign evict   = (occ_ff >= eff_capacity(cap_ff)) && (occ_ff != '0) && vic_found_ff;

   always_comb begin
      valid_post = valid_ff;
      if (evict) valid_post[vic_ff] = 1'b0;
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!valid_post[i]) begin
            free_found = 1'b1;
            free_slot  = ADDR_W'(i);
         end
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (kvs_we) kvs_mem[kvs_waddr] <= kvs_wdata;
      if (rank_we) rank_mem[rd_addr_ff] <= rank_wdata;
      if (issue) begin
         kvs_q_ff  <= kvs_mem[rd_addr];
         rank_q_ff <= rank_mem[rd_addr];
      end
   end

   always_comb begin
      kvs_we    = 1'b0;
      kvs_waddr = slot_ff;
      kvs_wdata = '{key: cur_ff.key, value: cur_ff.value, stamp: time_ff};
      if (state_ff == ST_DECIDE && cur_ff.command == CMD_PUSH) begin
         if (found_ff) begin
            kvs_we = 1'b1;
         end else if (free_found) begin
            kvs_we    = 1'b1;
            kvs_waddr = free_slot;
         end
      end
   end

   // renumber ranks: target goes to zero, more recent valid entries move down
   always_comb begin
      rank_we    = 1'b0;
      rank_wdata = rank_q_ff + RANK_W'(1);
      if (state_ff == ST_RANK && rd_v_ff) begin
         if (rd_addr_ff == tgt_ff) begin
            rank_we    = 1'b1;
            rank_wdata = '0;
         end else if (valid_ff[rd_addr_ff] && ({1'b0, rank_q_ff} < thr_ff)) begin
            rank_we = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_payload.command == CMD_GET || req_payload.command == CMD_PUSH)
                  state_in = ST_SCAN;
               else
                  state_in = ST_DONE;
            end
         end
         ST_SCAN:   if (!issue && !rd_v_ff) state_in = ST_DECIDE;
         ST_DECIDE: begin
            state_in = ST_DONE;
            if (cur_ff.command == CMD_GET) begin
               if (found_ff && age <= max_age_ff) state_in = ST_RANK;
            end else if (found_ff || free_found) begin
               state_in = ST_RANK;
            end
         end
         ST_RANK:   if (!issue && !rd_v_ff) state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= 5'd16;
         max_age_ff   <= 32'd1000;
         time_ff      <= '0;
         occ_ff       <= '0;
         valid_ff     <= '0;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_v_ff  <= issue;
         if (csr_we) begin
            if (csr_index == CSR_CAPACITY) cap_ff <= csr_wdata[4:0];
            else                           max_age_ff <= csr_wdata;
         end
         if (state_ff == ST_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)                 rsp_valid_ff <= 1'b0;
         if (state_ff == ST_IDLE && req_valid && req_payload.command == CMD_TICK)
            time_ff <= time_ff + WORD_W'(1);
         if (state_ff == ST_DECIDE && cur_ff.command == CMD_PUSH && !found_ff) begin
            if (free_found) begin
               valid_ff <= valid_post | (DEPTH'(1) << free_slot);
               occ_ff   <= evict ? occ_ff : occ_ff + CNT_W'(1);
            end else begin
               valid_ff <= valid_post;
               if (evict) occ_ff <= occ_last;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr;
      if (issue) cnt_ff <= cnt_ff + CNT_W'(1);
      unique case (state_ff)
         ST_IDLE: begin
            cur_ff       <= req_payload;
            cnt_ff       <= '0;
            found_ff     <= 1'b0;
            vic_found_ff <= 1'b0;
            hit_ff       <= 1'b0;
            data_ff      <= '0;
            ev_ff        <= 1'b0;
         end
         ST_SCAN: begin
            if (rd_v_ff && valid_ff[rd_addr_ff]) begin
               if (!found_ff && kvs_q_ff.key == cur_ff.key) begin
                  found_ff     <= 1'b1;
                  slot_ff      <= rd_addr_ff;
                  slot_rank_ff <= rank_q_ff;
                  slot_ent_ff  <= kvs_q_ff;
               end
               if (!vic_found_ff && CNT_W'(rank_q_ff) == occ_last) begin
                  vic_found_ff <= 1'b1;
                  vic_ff       <= rd_addr_ff;
               end
            end
         end
         ST_DECIDE: begin
            cnt_ff <= '0;
            if (cur_ff.command == CMD_PUSH && !found_ff) begin
               ev_ff  <= evict;
               tgt_ff <= free_slot;
               // a new entry pushes every other valid entry down
               thr_ff <= (RANK_W + 1)'(DEPTH);
            end else begin
               tgt_ff <= slot_ff;
               thr_ff <= {1'b0, slot_rank_ff};
            end
            if (cur_ff.command == CMD_GET && found_ff && age <= max_age_ff) begin
               hit_ff  <= 1'b1;
               data_ff <= slot_ent_ff.value;
            end
         end
         ST_RANK: ;
         ST_DONE: begin
            if (out_free) begin
               rsp_ff.hit     <= hit_ff;
               rsp_ff.data    <= data_ff;
               rsp_ff.evicted <= ev_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// File: verif/tb_lru_cache_with_expiry_top.sv
// ----------------------------------------------------------------------------
// tb_lru_cache_with_expiry_top
// Self-checking bench for the lru cache with expiry: directed and random
// get, push and tick traffic under several capacity and age-limit settings,
// each result compared against a behavioral model of the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lru_cache_with_expiry_top;
   import lcwe_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_payload;
   logic        csr_we;
   logic        csr_index;
   logic [31:0] csr_wdata;

   lru_cache_with_expiry_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // model state
   logic [4:0]  mdl_capacity;
   logic [31:0] mdl_max_age;
   logic [31:0] mdl_key [DEPTH];
   logic [31:0] mdl_value [DEPTH];
   logic [31:0] mdl_stamp [DEPTH];
   logic        mdl_valid [DEPTH];
   int          mdl_rank [DEPTH];
   int          mdl_count;
   logic [31:0] mdl_now;

   rsp_type     pending_rsp[$];
   int          mismatch_count;
   logic [31:0] key_pool [8];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int find_slot(logic [31:0] k);
      for (int i = 0; i < DEPTH; i++)
         if (mdl_valid[i] && mdl_key[i] == k) return i;
      return -1;
   endfunction

   function automatic void promote(int s);
      int r;
      r = mdl_rank[s];
      for (int i = 0; i < DEPTH; i++)
         if (mdl_valid[i] && mdl_rank[i] < r) mdl_rank[i]++;
      mdl_rank[s] = 0;
   endfunction

   function automatic rsp_type predict_lookup(req_type rq);
      rsp_type     r;
      int          s;
      int          cap;
      logic [31:0] age;
      r = '0;
      case (rq.command)
         CMD_GET: begin
            s = find_slot(rq.key);
            if (s >= 0) begin
               age = mdl_now - mdl_stamp[s];
               if (age <= mdl_max_age) begin
                  promote(s);
                  r.hit  = 1'b1;
                  r.data = mdl_value[s];
               end
            end
         end
         CMD_PUSH: begin
            s = find_slot(rq.key);
            if (s >= 0) begin
               mdl_value[s] = rq.value;
               mdl_stamp[s] = mdl_now;
               promote(s);
            end else begin
               cap = (mdl_capacity < 1) ? 1 : (mdl_capacity > DEPTH ? DEPTH : mdl_capacity);
               if (mdl_count >= cap && mdl_count > 0) begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (mdl_valid[i] && mdl_rank[i] == mdl_count - 1) begin
                        mdl_valid[i] = 1'b0;
                        mdl_count--;
                        r.evicted = 1'b1;
                        break;
                     end
                  end
               end
               s = -1;
               for (int i = 0; i < DEPTH; i++)
                  if (!mdl_valid[i]) begin
                     s = i;
                     break;
                  end
               if (s >= 0) begin
                  for (int i = 0; i < DEPTH; i++)
                     if (mdl_valid[i]) mdl_rank[i]++;
                  mdl_key[s]   = rq.key;
                  mdl_value[s] = rq.value;
                  mdl_stamp[s] = mdl_now;
                  mdl_valid[s] = 1'b1;
                  mdl_rank[s]  = 0;
                  mdl_count++;
               end
            end
         end
         CMD_TICK: mdl_now = mdl_now + 32'd1;
         default: ;
      endcase
      return r;
   endfunction

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // result checker with random stall on the response side
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected transfer: got %p", rsp_payload);
            end else begin
               rsp_type e;
               e = pending_rsp.pop_front();
               if (e.hit !== rsp_payload.hit || e.data !== rsp_payload.data ||
                   e.evicted !== rsp_payload.evicted) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch: expected hit %0b data %0d evicted %0b,",
                               " got hit %0b data %0d evicted %0b"},
                              e.hit, e.data, e.evicted, rsp_payload.hit, rsp_payload.data,
                              rsp_payload.evicted);
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < 30) ? (gap_length() != 0) : 1'b0;
      end
   end

   // valid stays high after a transfer until the next item or an idle gap
   task automatic send_req(logic [1:0] cmd, logic [31:0] k, logic [31:0] v);
      req_type rq;
      rsp_type exp_rsp;
      int      g;
      g = gap_length();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      rq.command = cmd;
      rq.key     = k;
      rq.value   = v;
      req_valid   <= 1'b1;
      req_payload <= rq;
      do @(posedge clock); while (req_stall);
      exp_rsp = predict_lookup(rq);
      pending_rsp = {pending_rsp, exp_rsp};
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] d);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CAPACITY) mdl_capacity = d[4:0];
      else mdl_max_age = d;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 7)];
      return $urandom();
   endfunction

   task automatic test_directed();
      send_req(CMD_GET, 32'h0000_0005, 32'h0);
      send_req(CMD_PUSH, 32'h8000_0000, 32'h7FFF_FFFF);
      send_req(CMD_PUSH, 32'h7FFF_FFFF, 32'h8000_0000);
      send_req(CMD_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_req(CMD_PUSH, 32'h0, 32'h0);
      send_req(CMD_GET, 32'h8000_0000, 32'h0);
      send_req(CMD_GET, 32'hFFFF_FFFF, 32'h1234);
      send_req(CMD_PUSH, 32'h7FFF_FFFF, 32'h5555_AAAA);
      send_req(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain();
      write_csr(CSR_MAX_AGE, 32'd2);
      // stale get keeps the entry, a push of the same key restamps it
      send_req(CMD_TICK, 32'h0, 32'h0);
      send_req(CMD_TICK, 32'h0, 32'h0);
      send_req(CMD_TICK, 32'h0, 32'h0);
      send_req(CMD_GET, 32'h0, 32'h0);
      send_req(CMD_PUSH, 32'h0, 32'h0BAD_F00D);
      send_req(CMD_GET, 32'h0, 32'h0);
      drain();
      // lowering capacity below occupancy
      write_csr(CSR_CAPACITY, 32'd2);
      send_req(CMD_PUSH, 32'h0000_1111, 32'h1);
      send_req(CMD_PUSH, 32'h0000_2222, 32'h2);
      send_req(CMD_GET, 32'h0000_1111, 32'h0);
      drain();
      write_csr(CSR_CAPACITY, 32'd0);
      send_req(CMD_PUSH, 32'h0000_3333, 32'h3);
      send_req(CMD_GET, 32'h0000_3333, 32'h0);
      drain();
   endtask

   task automatic test_random_phase(logic [4:0] cap, logic [31:0] age, int n);
      int          p;
      logic [1:0]  cmd;
      write_csr(CSR_CAPACITY, {27'd0, cap});
      write_csr(CSR_MAX_AGE, age);
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
      for (int i = 0; i < n; i++) begin
         p = $urandom_range(0, 99);
         cmd = (p < 40) ? CMD_GET : (p < 80) ? CMD_PUSH : (p < 98) ? CMD_TICK : CMD_UNUSED;
         send_req(cmd, pick_key(), $urandom());
         if (i == n / 2) drain();
      end
      drain();
   endtask

   task automatic test_time_wrap();
      write_csr(CSR_MAX_AGE, 32'hFFFF_FFFF);
      // jump the model and block clocks are shared, so just tick past a small age
      send_req(CMD_PUSH, 32'h0000_ABCD, 32'h1);
      for (int i = 0; i < 5; i++) send_req(CMD_TICK, 32'h0, 32'h0);
      send_req(CMD_GET, 32'h0000_ABCD, 32'h0);
      drain();
   endtask

   initial begin
      mismatch_count = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_CAPACITY;
      csr_wdata   = '0;
      mdl_capacity = 5'd16;
      mdl_max_age  = 32'd1000;
      mdl_count    = 0;
      mdl_now      = '0;
      for (int i = 0; i < DEPTH; i++) begin
         mdl_valid[i] = 1'b0;
         mdl_rank[i]  = 0;
         mdl_key[i]   = '0;
         mdl_value[i] = '0;
         mdl_stamp[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_time_wrap();
      test_random_phase(5'd16, 32'd1000, 300);
      test_random_phase(5'd4, 32'd3, 300);
      test_random_phase(5'd1, 32'd0, 200);
      test_random_phase(5'd31, 32'hFFFF_FFFF, 300);
      test_random_phase(5'd8, 32'd10, 300);
      test_random_phase(5'd0, 32'd5, 150);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
